// ===== rtl/nca_pkg.sv =====
// Package for the nearest-centroid anomaly block: widths, codes, shared types.
// It has no dependencies. Every RTL file of the block imports it.
`default_nettype none
package nca_pkg;

  localparam int NUM_ENTRIES = 128;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int DIMS        = 5;
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MAG_W       = 16;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 3;
  localparam int THR_W       = 16;
  localparam int ROOT_W      = 18;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int STEP_W      = $clog2(ROOT_W);
  localparam int CNT_W       = 8;
  localparam int IDX_FIELD_W = 7;
  localparam int ENTRY_W     = THR_W + DIMS * COORD_W;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(128);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [DIMS-1:0] coord_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } state_t;

  // Tag that travels with an entry through the distance pipeline.
  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic [THR_W-1:0]  thr;
  } dist_tag_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/nca_store.sv =====
// Centroid and threshold memory: one write port, one registered read port.
// Depends on nca_pkg.
`default_nettype none
module nca_store (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [nca_pkg::ADDR_W-1:0] wr_addr,
  input  wire nca_pkg::coord_vec_t        wr_coords,
  input  wire logic [nca_pkg::THR_W-1:0]  wr_thr,
  input  wire logic                       rd_en,
  input  wire logic [nca_pkg::ADDR_W-1:0] rd_addr,
  output nca_pkg::coord_vec_t             rd_coords,
  output logic [nca_pkg::THR_W-1:0]       rd_thr
);
  import nca_pkg::*;

  logic [ENTRY_W-1:0] mem [NUM_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_thr, wr_coords};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_thr    = rd_data_r[ENTRY_W-1 -: THR_W];
  assign rd_coords = rd_data_r[DIMS*COORD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/nca_dist.sv =====
// Three-stage squared-distance pipeline: difference, square, sum of five lanes.
// Depends on nca_pkg.
`default_nettype none
module nca_dist (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_v,
  input  wire nca_pkg::dist_tag_t   in_tag,
  input  wire nca_pkg::coord_vec_t  cent,
  input  wire nca_pkg::coord_vec_t  query,
  output logic                      out_v,
  output nca_pkg::dist_tag_t        out_tag,
  output logic [nca_pkg::SUM_W-1:0] out_sum,
  output logic                      busy
);
  import nca_pkg::*;

  logic                    v1_r, v2_r, v3_r;
  dist_tag_t               tag1_r, tag2_r, tag3_r;
  logic signed [DIFF_W-1:0] diff_r [DIMS];
  logic [SQ_W-1:0]         sq_r [DIMS];
  logic [SUM_W-1:0]        sum_r;
  logic [MAG_W-1:0]        mag [DIMS];
  logic [SUM_W-1:0]        sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < DIMS; d++) begin
      mag[d]  = diff_r[d][DIFF_W-1] ? MAG_W'(-diff_r[d]) : MAG_W'(diff_r[d]);
      sum_nxt = sum_nxt + SUM_W'(sq_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    for (int d = 0; d < DIMS; d++) begin
      diff_r[d] <= $signed({cent[d][COORD_W-1], cent[d]})
                 - $signed({query[d][COORD_W-1], query[d]});
      sq_r[d]   <= mag[d] * mag[d];
    end
    sum_r <= sum_nxt;
  end

  assign out_v   = v3_r;
  assign out_tag = tag3_r;
  assign out_sum = sum_r;
  assign busy    = v1_r | v2_r | v3_r;

endmodule
`default_nettype wire

// ===== rtl/nca_isqrt.sv =====
// Iterative floor square root, one root bit per cycle on a shared subtractor.
// Depends on nca_pkg.
`default_nettype none
module nca_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [nca_pkg::SUM_W-1:0]   radicand,
  output nca_pkg::sqrt_stat_t              stat,
  output logic [nca_pkg::ROOT_W-1:0]       root,
  output logic                             rem_nz
);
  import nca_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({root_r, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;
  assign rem_nz    = (rem_r != '0);

endmodule
`default_nettype wire

// ===== rtl/nearest_centroid_anomaly.sv =====
// Top level of the nearest-centroid anomaly detector: sequencer, best-match
// tracking and output register. Depends on nca_pkg, nca_store, nca_dist, nca_isqrt.
//
// Usage. The input channel carries two kinds of beat. A write beat (action 0)
// stores five signed Q8.8 coordinates and an unsigned Q8.8 threshold at
// entry_index and gives no result. A query beat (action 1) compares its
// coordinates with entries 0 .. n-1, where n is the cfg register (0 counts
// as 1, values above the store depth saturate to the depth), and gives one
// result beat: the lowest index at the minimum squared distance, the floor
// square root of that distance, and a flag that is set when the distance is
// above the entry's threshold. Entries must be written before they are queried.
// Query sequence: a query reads one stored entry per cycle through the
// single memory read port, then waits while the read register and the
// three-stage distance pipeline empty and the square root is started, then
// runs the bit-serial square-root unit and hands the result to the output
// register. out_valid rises when the result is loaded, and in_ready, low from
// the accepted query until then, returns with it. The result sits in an
// output register; while it waits for out_ready the block still accepts new
// beats, and a finished query only stalls if the previous result has not yet
// been taken. Reset returns the sequencer to idle, drops out_valid and sets
// the count register to 128; the store is not cleared.
`default_nettype none
module nearest_centroid_anomaly (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_action,
  input  wire logic [nca_pkg::IDX_FIELD_W-1:0]  in_entry_index,
  input  wire logic signed [nca_pkg::COORD_W-1:0] in_coord_0,
  input  wire logic signed [nca_pkg::COORD_W-1:0] in_coord_1,
  input  wire logic signed [nca_pkg::COORD_W-1:0] in_coord_2,
  input  wire logic signed [nca_pkg::COORD_W-1:0] in_coord_3,
  input  wire logic signed [nca_pkg::COORD_W-1:0] in_coord_4,
  input  wire logic [nca_pkg::THR_W-1:0]        in_entry_threshold,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [nca_pkg::IDX_FIELD_W-1:0]       out_best_index,
  output logic [nca_pkg::ROOT_W-1:0]            out_best_distance,
  output logic                                  out_anomaly,
  input  wire logic                             cfg_we,
  input  wire logic [nca_pkg::CNT_W-1:0]        cfg_wdata
);
  import nca_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] k_r, last_r;
  coord_vec_t        q_r;
  logic              rd_v_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              first_r;
  logic [SUM_W-1:0]  best_sq_r;
  logic [ADDR_W-1:0] best_idx_r;
  logic [THR_W-1:0]  best_thr_r;
  logic              out_valid_r;
  logic [IDX_FIELD_W-1:0] out_idx_r;
  logic [ROOT_W-1:0] out_dist_r;
  logic              out_anom_r;

  coord_vec_t        in_coords;
  logic              in_fire, wr_en, q_start;
  logic [31:0]       wr_idx32, n32;
  logic [ADDR_W-1:0] last_nxt;
  logic              rd_en, sqrt_start, load_out, drained;
  coord_vec_t        rd_coords;
  logic [THR_W-1:0]  rd_thr;
  dist_tag_t         rd_tag;
  logic              d_v, d_busy;
  dist_tag_t         d_tag;
  logic [SUM_W-1:0]  d_sum;
  sqrt_stat_t        sq_stat;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_rem_nz;
  logic [ROOT_W-1:0] thr_ext;
  logic              anomaly_now;

  assign in_coords = {in_coord_4, in_coord_3, in_coord_2, in_coord_1, in_coord_0};
  assign in_fire   = in_valid && in_ready;
  assign wr_idx32  = 32'(in_entry_index);
  assign wr_en     = in_fire && (in_action == ACT_WRITE) && (wr_idx32 < 32'(NUM_ENTRIES));
  assign q_start   = in_fire && (in_action == ACT_QUERY);

  // Number of entries searched, clamped to 1 .. NUM_ENTRIES.
  always_comb begin
    n32 = (count_r == '0) ? 32'd1 : 32'(count_r);
    if (n32 > 32'(NUM_ENTRIES)) begin
      n32 = 32'(NUM_ENTRIES);
    end
    last_nxt = ADDR_W'(n32 - 32'd1);
  end

  assign drained = !rd_v_r && !d_busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_start) state_nxt = ST_SCAN;
      ST_SCAN:  if (k_r == last_r) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drained) state_nxt = ST_ROOT;
      ST_ROOT:  if (sq_stat.done) state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  rd_en = 1'b1;
      ST_DRAIN: sqrt_start = drained;
      ST_ROOT:  ;
      ST_OUT:   load_out = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_RESET;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_en;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers; first_r marks that no entry has been seen yet.
  always_ff @(posedge clk) begin
    rd_idx_r <= k_r;
    if (q_start) begin
      q_r     <= in_coords;
      k_r     <= '0;
      last_r  <= last_nxt;
      first_r <= 1'b1;
    end else if (rd_en) begin
      k_r <= k_r + 1'b1;
    end
    if (d_v && (first_r || d_sum < best_sq_r)) begin
      best_sq_r  <= d_sum;
      best_idx_r <= d_tag.idx;
      best_thr_r <= d_tag.thr;
      first_r    <= 1'b0;
    end
    if (load_out) begin
      out_idx_r  <= IDX_FIELD_W'(32'(best_idx_r));
      out_dist_r <= sq_root;
      out_anom_r <= anomaly_now;
    end
  end

  // D > t*t holds exactly when floor(sqrt(D)) > t, or equals t with a remainder.
  assign thr_ext     = ROOT_W'(best_thr_r);
  assign anomaly_now = (sq_root > thr_ext) || ((sq_root == thr_ext) && sq_rem_nz);

  assign rd_tag.idx = rd_idx_r;
  assign rd_tag.thr = rd_thr;

  nca_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (ADDR_W'(wr_idx32)),
    .wr_coords (in_coords),
    .wr_thr    (in_entry_threshold),
    .rd_en     (rd_en),
    .rd_addr   (k_r),
    .rd_coords (rd_coords),
    .rd_thr    (rd_thr)
  );

  nca_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (rd_v_r),
    .in_tag  (rd_tag),
    .cent    (rd_coords),
    .query   (q_r),
    .out_v   (d_v),
    .out_tag (d_tag),
    .out_sum (d_sum),
    .busy    (d_busy)
  );

  nca_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (best_sq_r),
    .stat     (sq_stat),
    .root     (sq_root),
    .rem_nz   (sq_rem_nz)
  );

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_distance = out_dist_r;
  assign out_anomaly       = out_anom_r;

endmodule
`default_nettype wire

// ===== sim/nca_match_checker.sv =====
// Result checker for the nearest-centroid anomaly block. It mirrors the
// centroid store and the count register, predicts each query and compares.
// Depends on nca_pkg only.
module nca_match_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_action,
  input  logic [nca_pkg::IDX_FIELD_W-1:0]  in_entry_index,
  input  nca_pkg::coord_t                  in_coord_0,
  input  nca_pkg::coord_t                  in_coord_1,
  input  nca_pkg::coord_t                  in_coord_2,
  input  nca_pkg::coord_t                  in_coord_3,
  input  nca_pkg::coord_t                  in_coord_4,
  input  logic [nca_pkg::THR_W-1:0]        in_entry_threshold,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [nca_pkg::IDX_FIELD_W-1:0]  out_best_index,
  input  logic [nca_pkg::ROOT_W-1:0]       out_best_distance,
  input  logic                             out_anomaly,
  input  logic                             cfg_we,
  input  logic [nca_pkg::CNT_W-1:0]        cfg_wdata,
  output int                               mismatches,
  output int                               results_waiting,
  output int                               results_checked,
  output int                               anomalies_seen
);
  import nca_pkg::*;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index;
    logic [ROOT_W-1:0]      distance;
    logic                   anomaly;
  } match_t;

  match_t           expected_matches [$];
  coord_vec_t       centroid_mem [NUM_ENTRIES];
  logic [THR_W-1:0] limit_mem [NUM_ENTRIES];
  logic [CNT_W-1:0] search_count;
  match_t           got;
  match_t           want;

  // Largest root whose square does not exceed x, found one bit at a time.
  function automatic logic [ROOT_W-1:0] floor_root(input longint x);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      if (longint'(trial) * longint'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  function automatic match_t nearest_match(input coord_vec_t probe);
    match_t m;
    int     span;
    int     best_k;
    longint best_sq;
    longint sq;
    longint diff;
    coord_t a;
    coord_t q;
    if (search_count == 0) span = 1;
    else if (search_count > NUM_ENTRIES) span = NUM_ENTRIES;
    else span = int'(search_count);
    best_sq = 0;
    best_k = 0;
    for (int k = 0; k < span; k++) begin
      sq = 0;
      for (int d = 0; d < DIMS; d++) begin
        a = centroid_mem[k][d];
        q = probe[d];
        diff = longint'(a) - longint'(q);
        sq += diff * diff;
      end
      // Strictly smaller only, so the lowest index keeps a tie.
      if (k == 0 || sq < best_sq) begin
        best_sq = sq;
        best_k = k;
      end
    end
    m.index = IDX_FIELD_W'(best_k);
    m.distance = floor_root(best_sq);
    m.anomaly = best_sq > longint'(limit_mem[best_k]) * longint'(limit_mem[best_k]);
    return m;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      search_count = CNT_RESET;
      expected_matches.delete();
      mismatches = 0;
      results_waiting = 0;
      results_checked = 0;
      anomalies_seen = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.index = out_best_index;
        got.distance = out_best_distance;
        got.anomaly = out_anomaly;
        if (expected_matches.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: index %0d distance %0d anomaly %0b",
                   $time, got.index, got.distance, got.anomaly);
        end else begin
          want = expected_matches.pop_front();
          results_checked++;
          if (got.anomaly === 1'b1) anomalies_seen++;
          if (got.index !== want.index) begin
            mismatches++;
            $display("%0t: best_index expected %0d, got %0d", $time, want.index, got.index);
          end
          if (got.distance !== want.distance) begin
            mismatches++;
            $display("%0t: best_distance expected %0d, got %0d",
                     $time, want.distance, got.distance);
          end
          if (got.anomaly !== want.anomaly) begin
            mismatches++;
            $display("%0t: anomaly expected %0b, got %0b", $time, want.anomaly, got.anomaly);
          end
        end
      end
      if (cfg_we === 1'b1) search_count = cfg_wdata;
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        if (in_action == ACT_WRITE) begin
          centroid_mem[in_entry_index] = {in_coord_4, in_coord_3, in_coord_2, in_coord_1,
                                          in_coord_0};
          limit_mem[in_entry_index] = in_entry_threshold;
        end else begin
          expected_matches.insert(expected_matches.size(),
                                  nearest_match({in_coord_4, in_coord_3, in_coord_2,
                                                 in_coord_1, in_coord_0}));
        end
      end
      results_waiting = expected_matches.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the nearest-centroid anomaly testbench: clock, reset, beat stimulus,
// receiver stalls, watchdog and verdict. Depends on nca_pkg, the block
// nearest_centroid_anomaly and the checker nca_match_checker.
module tb_top;
  import nca_pkg::*;

  localparam int RESET_CYCLES   = 5;
  // Covers a query at the full store depth with margin; it is used wherever
  // the block must be given time to settle.
  localparam int QUERY_LATENCY  = 200;
  // Length of the one long receiver hold-off that fills the block.
  localparam int LONG_HOLD      = 1500;
  // The slowest correct gap between accepted beats is the long hold plus a
  // full-depth query plus a settle pause; this is several times that.
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASE_BEATS    = 95;

  typedef struct packed {
    logic                   action;
    logic [IDX_FIELD_W-1:0] index;
    coord_vec_t             coords;
    logic [THR_W-1:0]       limit;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_action = ACT_WRITE;
  logic [IDX_FIELD_W-1:0] in_entry_index = '0;
  coord_t                 in_coord_0 = '0;
  coord_t                 in_coord_1 = '0;
  coord_t                 in_coord_2 = '0;
  coord_t                 in_coord_3 = '0;
  coord_t                 in_coord_4 = '0;
  logic [THR_W-1:0]       in_entry_threshold = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [IDX_FIELD_W-1:0] out_best_index;
  logic [ROOT_W-1:0]      out_best_distance;
  logic                   out_anomaly;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  int mismatches;
  int results_waiting;
  int results_checked;
  int anomalies_seen;

  // Stimulus knobs and bookkeeping.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int search_span = NUM_ENTRIES;
  int writes_sent = 0;
  int queries_sent = 0;
  int idle_cycles = 0;

  // The stimulus side keeps its own copy of what it has stored, so that queries
  // can be aimed close to real centroids and writes can copy another entry's point.
  coord_vec_t shadow [NUM_ENTRIES];

  always #5 clk = ~clk;

  nearest_centroid_anomaly dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_coord_0         (in_coord_0),
    .in_coord_1         (in_coord_1),
    .in_coord_2         (in_coord_2),
    .in_coord_3         (in_coord_3),
    .in_coord_4         (in_coord_4),
    .in_entry_threshold (in_entry_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_best_index     (out_best_index),
    .out_best_distance  (out_best_distance),
    .out_anomaly        (out_anomaly),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  nca_match_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_coord_0         (in_coord_0),
    .in_coord_1         (in_coord_1),
    .in_coord_2         (in_coord_2),
    .in_coord_3         (in_coord_3),
    .in_coord_4         (in_coord_4),
    .in_entry_threshold (in_entry_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_best_index     (out_best_index),
    .out_best_distance  (out_best_distance),
    .out_anomaly        (out_anomaly),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .results_waiting    (results_waiting),
    .results_checked    (results_checked),
    .anomalies_seen     (anomalies_seen)
  );

  // Receiver. It changes out_ready at the falling edge only. A long hold-off
  // is requested by bumping hold_requests; the count of held cycles is kept
  // here so the sender can keep offering beats during the hold.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat accepted for %0d cycles at %0t", idle_cycles, $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic cmd_beat_t mk(input logic act, input int idx, input int c0,
                                   input int c1, input int c2, input int c3,
                                   input int c4, input int limit);
    cmd_beat_t b;
    b.action = act;
    b.index = IDX_FIELD_W'(idx);
    b.coords = {coord_t'(c4), coord_t'(c3), coord_t'(c2), coord_t'(c1), coord_t'(c0)};
    b.limit = THR_W'(limit);
    return b;
  endfunction

  // Coordinates lean toward the extremes and toward small values, so that
  // both the sign handling and the widest differences are hit often.
  function automatic coord_t random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(int'($urandom_range(0, 511)) - 256);
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Thresholds spread over every magnitude so the anomaly flag goes both ways.
  function automatic logic [THR_W-1:0] random_limit();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return '1;
      default: return THR_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    endcase
  endfunction

  // A point near a stored coordinate, offset by a random power-of-two scale.
  function automatic coord_t near_coord(input coord_t base);
    int s;
    int off;
    s = $urandom_range(0, 14);
    off = int'($urandom_range(0, 2 << s)) - (1 << s);
    return coord_t'(int'(base) + off);
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        base;
    logic      close;
    b.index = IDX_FIELD_W'($urandom_range(0, NUM_ENTRIES - 1));
    b.limit = random_limit();
    if ($urandom_range(0, 99) < 40) begin
      b.action = ACT_WRITE;
      // Now and then a copy of another entry's point, which sets up ties.
      if ($urandom_range(0, 3) == 0) begin
        b.coords = shadow[$urandom_range(0, NUM_ENTRIES - 1)];
      end else begin
        for (int d = 0; d < DIMS; d++) b.coords[d] = random_coord();
      end
    end else begin
      b.action = ACT_QUERY;
      base = $urandom_range(0, search_span - 1);
      close = ($urandom_range(0, 9) < 7);
      for (int d = 0; d < DIMS; d++) begin
        b.coords[d] = close ? near_coord(shadow[base][d]) : random_coord();
      end
    end
    return b;
  endfunction

  // Offers one beat and returns at the falling edge after it was taken, with
  // in_valid still high. The caller either offers the next beat at once or
  // lowers in_valid in that same step.
  task automatic send_beat(input cmd_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= b.action;
    in_entry_index <= b.index;
    in_coord_0 <= b.coords[0];
    in_coord_1 <= b.coords[1];
    in_coord_2 <= b.coords[2];
    in_coord_3 <= b.coords[3];
    in_coord_4 <= b.coords[4];
    in_entry_threshold <= b.limit;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (b.action == ACT_WRITE) begin
      writes_sent++;
      shadow[b.index] = b.coords;
    end else begin
      queries_sent++;
    end
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // The loop always waits for a falling edge first, so in_valid is never
  // raised again in the step that lowered it.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_waiting != 0);
  endtask

  // The count register is only written while the block is idle. A write beat
  // gives no result, so a settle pause follows the drain before the update.
  task automatic set_count(input int value);
    drain_results();
    repeat (QUERY_LATENCY) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (value == 0) search_span = 1;
    else if (value > NUM_ENTRIES) search_span = NUM_ENTRIES;
    else search_span = value;
  endtask

  task automatic run_phase(input int count, input int sidle, input int rstall,
                           input bit long_hold, input bit mid_drain);
    set_count(count);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (long_hold) hold_requests <= hold_requests + 1;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      if (mid_drain && i == PHASE_BEATS / 2) drain_results();
      send_beat(random_beat());
    end
  endtask

  initial begin
    cmd_beat_t fill;
    for (int k = 0; k < NUM_ENTRIES; k++) shadow[k] = '0;

    // Synchronous reset, held for a few edges and released at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. With a count of zero only entry 0 is searched: widest
    // possible distance, zero distance against a zero threshold, and the
    // largest threshold.
    set_count(0);
    send_beat(mk(ACT_WRITE, 0, -32768, -32768, -32768, -32768, -32768, 0));
    send_beat(mk(ACT_QUERY, 127, 32767, 32767, 32767, 32767, 32767, 65535));
    send_beat(mk(ACT_QUERY, 127, -32768, -32768, -32768, -32768, -32768, 65535));
    send_beat(mk(ACT_WRITE, 0, 0, 0, 0, 0, 0, 65535));
    send_beat(mk(ACT_QUERY, 0, 32767, 32767, 32767, 32767, 32767, 0));
    send_beat(mk(ACT_QUERY, 0, -32768, 0, 0, 0, 0, 0));

    // Four entries: entries 1 and 2 share a point (tie goes to 1), entry 3
    // has a threshold of 1.0 for the at-threshold and just-over cases, and
    // a query halfway between entries 0 and 3 ties toward entry 0.
    set_count(4);
    send_beat(mk(ACT_WRITE, 1, 10000, 10000, 10000, 10000, 10000, 1));
    send_beat(mk(ACT_WRITE, 2, 10000, 10000, 10000, 10000, 10000, 2000));
    send_beat(mk(ACT_WRITE, 3, -5000, -5000, -5000, -5000, -5000, 256));
    send_beat(mk(ACT_WRITE, 127, 32767, 32767, 32767, 32767, 32767, 65535));
    send_beat(mk(ACT_QUERY, 127, 10000, 10000, 10000, 10000, 10000, 0));
    send_beat(mk(ACT_QUERY, 0, 9990, 9990, 9990, 9990, 9990, 0));
    send_beat(mk(ACT_QUERY, 0, -4744, -5000, -5000, -5000, -5000, 0));
    send_beat(mk(ACT_QUERY, 0, -4744, -4999, -5000, -5000, -5000, 0));
    send_beat(mk(ACT_QUERY, 0, -4745, -5000, -5000, -5000, -5000, 0));
    send_beat(mk(ACT_QUERY, 0, -2500, -2500, -2500, -2500, -2500, 0));

    // Fill the rest of the store so that every later count is legal.
    for (int k = 4; k < NUM_ENTRIES - 1; k++) begin
      fill = random_beat();
      fill.action = ACT_WRITE;
      fill.index = IDX_FIELD_W'(k);
      send_beat(fill);
    end

    // Random phases over the count range, including the saturating values
    // and zero. The second phase starts with a long receiver hold-off while
    // the sender keeps offering, so the output register fills and the input
    // stalls. The fourth pauses the sender halfway until all results are in.
    run_phase(128, 0, 0, 1'b0, 1'b0);
    run_phase(1, 56, 0, 1'b1, 1'b0);
    run_phase(255, 0, 56, 1'b0, 1'b0);
    run_phase($urandom_range(2, 127), 19, 19, 1'b0, 1'b1);
    run_phase(0, 0, 0, 1'b0, 1'b0);
    run_phase(200, 19, 19, 1'b0, 1'b0);

    drain_results();
    repeat (QUERY_LATENCY) @(negedge clk);

    $display("Run covered %0d entry writes and %0d queries over counts 0 to 255,",
             writes_sent, queries_sent);
    $display("with %0d results checked, %0d of them flagged as anomalies.",
             results_checked, anomalies_seen);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
